/* src/byte_rle_codec_core_assert.svh */
// Assertion macros for the checker of the byte run-length codec.
`ifndef BYTE_RLE_CODEC_CORE_ASSERT_SVH
`define BYTE_RLE_CODEC_CORE_ASSERT_SVH

// Both macros expect aclk and aresetn in scope.
// The consequent must hold in the same cycle as the antecedent.
`define RLEC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rlec assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RLEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rlec assertion failed");

`endif

/* src/rlec_pkg.sv */
package rlec_pkg;

    localparam logic [6:0] MAX_EXTRA = 7'd127;
    localparam logic [7:0] HDR_FLAG  = 8'h80;
    localparam int         BEAT_BYTES = 8;

    typedef struct packed {
        logic       end_of_stream;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic        last_of_run;
        logic [3:0]  out_count;
        logic [63:0] out_bytes;
    } out_t;

    typedef struct packed {
        logic       holding;
        logic [7:0] held_byte;
        logic [6:0] run_extra;
    } run_state_t;

    typedef struct packed {
        run_state_t  nxt;
        logic [31:0] word;
        logic [2:0]  count;
    } enc_res_t;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        last;
        logic [7:0]  rem_next;
    } fill_beat_t;

endpackage

/* src/rlec_enc.sv */
module rlec_enc (
    input  rlec_pkg::run_state_t cur,
    input  rlec_pkg::in_t        item,
    output rlec_pkg::enc_res_t   res
);
    import rlec_pkg::*;

    // Encoding of one run: length in the top two bits, first byte lowest.
    function automatic logic [17:0] code_run(input logic [7:0] held, input logic [6:0] extra);
        logic [17:0] r;
        if (extra != 7'd0) begin
            r = {2'd2, held, (HDR_FLAG | {1'b0, extra})};
        end else if (held[7]) begin
            r = {2'd2, held, HDR_FLAG};
        end else begin
            r = {2'd1, 8'h00, held};
        end
        return r;
    endfunction

    logic        join_run;
    logic [17:0] code_old;
    logic [17:0] code_new;
    logic [1:0]  len_old;
    logic [1:0]  len_new;
    run_state_t  st;

    always_comb begin
        join_run = cur.holding && (item.data_byte == cur.held_byte) &&
                   (cur.run_extra < MAX_EXTRA);
        code_old = code_run(cur.held_byte, cur.run_extra);
        len_old  = (cur.holding && !join_run) ? code_old[17:16] : 2'd0;
        if (join_run) begin
            st.holding   = 1'b1;
            st.held_byte = cur.held_byte;
            st.run_extra = cur.run_extra + 7'd1;
        end else begin
            st.holding   = 1'b1;
            st.held_byte = item.data_byte;
            st.run_extra = 7'd0;
        end
        code_new = code_run(st.held_byte, st.run_extra);
        len_new  = item.end_of_stream ? code_new[17:16] : 2'd0;
        if (item.end_of_stream) begin
            st.holding   = 1'b0;
            st.run_extra = 7'd0;
        end
        res.nxt   = st;
        res.word  = ((len_old != 2'd0) ? {16'h0000, code_old[15:0]} : 32'h0) |
                    ((len_new != 2'd0) ? ({16'h0000, code_new[15:0]} << {len_old, 3'b000})
                                       : 32'h0);
        res.count = {1'b0, len_old} + {1'b0, len_new};
    end

endmodule

/* src/rlec_fill.sv */
module rlec_fill (
    input  logic [7:0]           fill_byte,
    input  logic [7:0]           remaining,
    output rlec_pkg::fill_beat_t beat
);
    import rlec_pkg::*;

    logic [3:0] take;

    always_comb begin
        take = (remaining > 8'(BEAT_BYTES)) ? 4'(BEAT_BYTES) : remaining[3:0];
        for (int i = 0; i < BEAT_BYTES; i++) begin
            beat.bytes[i*8 +: 8] = (4'(i) < take) ? fill_byte : 8'h00;
        end
        beat.count    = take;
        beat.last     = (remaining <= 8'(BEAT_BYTES));
        beat.rem_next = remaining - {4'h0, take};
    end

endmodule

/* src/byte_rle_codec_core.sv */
// Byte run-length codec, PackBits style. With direction 0 it compresses:
// runs of up to 128 equal bytes become a header word byte (0x80 | extra)
// and the data byte, a lone byte below 0x80 passes alone, a lone byte of
// 0x80 or above is sent as 0x80 and the byte, and end_of_stream flushes
// the held run. With direction 1 it expands that format, and a header on
// the last input byte is dropped. A direction write clears any held run or
// pending header; cfg_ready is always high, and results of words already
// taken are still delivered in full. Results carry up to eight bytes,
// first byte in bits 7 to 0, unused bytes zero, with last_of_run on the
// final result of an input word. An input word is taken and, when it gives
// a compressed or literal result, that result sits in the output register
// in the cycle after; s_ready stays low until that register is empty and
// while a run is expanded. A run byte after a header loads the fill byte
// and count registers; the run of N bytes then comes from one fill unit
// in ST_FILL, at most eight bytes a cycle whenever the output is free.
module byte_rle_codec_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rlec_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rlec_pkg::out_t  m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data
);
    import rlec_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_FILL
    } state_t;

    state_t     state_reg, state_next;
    logic       dir_reg, dir_next;
    logic       pend_reg, pend_next;
    run_state_t run_reg, run_next;
    logic [7:0] fill_byte_reg, fill_byte_next;
    logic [7:0] rem_reg, rem_next;
    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg, m_data_next;

    enc_res_t   enc;
    fill_beat_t beat;
    logic       accept;
    logic       out_free;

    rlec_enc u_enc (
        .cur  (run_reg),
        .item (s_data),
        .res  (enc)
    );

    rlec_fill u_fill (
        .fill_byte (fill_byte_reg),
        .remaining (rem_reg),
        .beat      (beat)
    );

    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        pend_next      = pend_reg;
        run_next       = run_reg;
        fill_byte_next = fill_byte_reg;
        rem_next       = rem_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!dir_reg) begin
                        run_next = enc.nxt;
                        if (enc.count != 3'd0) begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{last_of_run: 1'b1,
                                             out_count: {1'b0, enc.count},
                                             out_bytes: {32'h0, enc.word}};
                        end
                    end else if (pend_reg) begin
                        fill_byte_next = s_data.data_byte;
                        rem_next       = {1'b0, run_reg.run_extra} + 8'd1;
                        pend_next      = 1'b0;
                        state_next     = ST_FILL;
                    end else if (s_data.data_byte[7]) begin
                        run_next.run_extra = s_data.data_byte[6:0];
                        pend_next          = !s_data.end_of_stream;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{last_of_run: 1'b1, out_count: 4'd1,
                                         out_bytes: {56'h0, s_data.data_byte}};
                    end
                end
            end
            ST_FILL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{last_of_run: beat.last, out_count: beat.count,
                                     out_bytes: beat.bytes};
                    rem_next     = beat.rem_next;
                    if (beat.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            dir_next         = cfg_data;
            run_next.holding = 1'b0;
            pend_next        = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dir_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            run_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dir_reg     <= dir_next;
            pend_reg    <= pend_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
        end
        fill_byte_reg <= fill_byte_next;
        rem_reg       <= rem_next;
        m_data_reg    <= m_data_next;
    end

endmodule

/* src/rlec_checker.sv */
`include "byte_rle_codec_core_assert.svh"

module rlec_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input rlec_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input rlec_pkg::out_t m_data,
    input logic           cfg_valid,
    input logic           cfg_ready,
    input logic           cfg_data
);
    import rlec_pkg::*;

    // A result word holds one to eight bytes; a count of zero wraps past eight.
    `RLEC_ASSERT_SAME(a_count_range, m_valid, (m_data.out_count - 4'd1) < 4'd8)

    // Only the final word of an input may be short.
    `RLEC_ASSERT_SAME(a_short_is_last, m_valid && (m_data.out_count != 4'd8), m_data.last_of_run)

    // New input is taken only once the output register has drained.
    `RLEC_ASSERT_SAME(a_ready_drained, s_ready, !m_valid)

    // A stalled result word holds steady.
    `RLEC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule

bind byte_rle_codec_core rlec_checker u_rlec_checker (.*);

/* test/rlec_stream_checker.sv */
`timescale 1ns / 1ps

module rlec_stream_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  rlec_pkg::in_t    s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  rlec_pkg::out_t   m_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_data,
    output int               mismatches,
    output int               beats_pending,
    output int               beats_checked
);
    import rlec_pkg::*;

    logic        expanding;
    logic [7:0]  held_byte;
    logic [6:0]  run_extra;
    logic        holding;
    logic        header_pending;
    logic [7:0]  codec_bytes [$];
    out_t        expected_beats [$];
    out_t        oldest;

    function automatic void append_held_run();
        if (run_extra != 7'd0) begin
            codec_bytes.push_back(HDR_FLAG | {1'b0, run_extra});
        end else if (held_byte[7]) begin
            codec_bytes.push_back(HDR_FLAG);
        end
        codec_bytes.push_back(held_byte);
    endfunction

    function automatic void predict_word(input in_t word);
        int   take;
        out_t beat;
        codec_bytes.delete();
        if (!expanding) begin
            if (holding && word.data_byte == held_byte && run_extra < MAX_EXTRA) begin
                run_extra = run_extra + 7'd1;
            end else begin
                if (holding) begin
                    append_held_run();
                end
                held_byte = word.data_byte;
                run_extra = 7'd0;
                holding   = 1'b1;
            end
            if (word.end_of_stream) begin
                append_held_run();
                holding   = 1'b0;
                run_extra = 7'd0;
            end
        end else begin
            if (header_pending) begin
                for (int i = 0; i <= int'(run_extra); i++) begin
                    codec_bytes.push_back(word.data_byte);
                end
                header_pending = 1'b0;
            end else if (word.data_byte[7]) begin
                run_extra      = word.data_byte[6:0];
                header_pending = 1'b1;
            end else begin
                codec_bytes.push_back(word.data_byte);
            end
            if (word.end_of_stream) begin
                header_pending = 1'b0;
            end
        end
        while (codec_bytes.size() > 0) begin
            take = (codec_bytes.size() > BEAT_BYTES) ? BEAT_BYTES : codec_bytes.size();
            beat = '0;
            for (int i = 0; i < take; i++) begin
                beat.out_bytes[8*i +: 8] = codec_bytes.pop_front();
            end
            beat.out_count   = take[3:0];
            beat.last_of_run = (codec_bytes.size() == 0);
            expected_beats.push_back(beat);
        end
    endfunction

    function automatic void note_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        $display("%0t: %s expected %h, got %h", $time, what, want, got);
        mismatches++;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expanding      = 1'b0;
            held_byte      = 8'd0;
            run_extra      = 7'd0;
            holding        = 1'b0;
            header_pending = 1'b0;
            expected_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                expanding      = cfg_data;
                holding        = 1'b0;
                header_pending = 1'b0;
            end
            if (s_valid && s_ready) begin
                predict_word(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %h", $time, m_data);
                    mismatches++;
                end else begin
                    oldest = expected_beats.pop_front();
                    if (m_data.out_bytes !== oldest.out_bytes) begin
                        note_mismatch("out_bytes", oldest.out_bytes, m_data.out_bytes);
                    end
                    if (m_data.out_count !== oldest.out_count) begin
                        note_mismatch("out_count", oldest.out_count, m_data.out_count);
                    end
                    if (m_data.last_of_run !== oldest.last_of_run) begin
                        note_mismatch("last_of_run", oldest.last_of_run, m_data.last_of_run);
                    end
                    beats_checked++;
                end
            end
        end
        beats_pending = expected_beats.size();
    end

endmodule

/* test/tb_byte_rle_codec_core.sv */
`timescale 1ns / 1ps

module tb_byte_rle_codec_core;
    import rlec_pkg::*;

    localparam logic DIR_COMPRESS = 1'b0;
    localparam logic DIR_EXPAND   = 1'b1;

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic s_valid   = 1'b0;
    logic s_ready;
    in_t  s_data    = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data  = 1'b0;

    int mismatches;
    int beats_pending;
    int beats_checked;
    int words_sent = 0;
    int dir_writes = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    always #1 aclk = ~aclk;

    byte_rle_codec_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rlec_stream_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .beats_pending (beats_pending),
        .beats_checked (beats_checked)
    );

    // The receiver switches among always ready, coin flips, rare acceptance and a
    // periodic stall, each held for a random stretch.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 80);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_ready <= (stall_left % 5 != 0);
            end
        endcase
    end

    task automatic offer_word(input logic [7:0] value, input logic eos);
        in_t word;
        int  gap;
        word.data_byte     = value;
        word.end_of_stream = eos;
        s_valid <= 1'b1;
        s_data  <= word;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_block();
        s_valid <= 1'b0;
        do @(negedge aclk); while (beats_pending != 0);
        repeat (24) @(posedge aclk);
    endtask

    task automatic set_direction(input logic dir);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data  <= dir;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dir_writes++;
    endtask

    task automatic compress_phase(input int budget, input bit with_full_run);
        int         start;
        int         len;
        int         pick;
        logic [7:0] value;
        if (with_full_run) begin
            value = 8'($urandom_range(0, 255));
            for (int i = 0; i < 129; i++) begin
                offer_word(value, i == 128);
            end
        end
        start = words_sent;
        while (words_sent - start < budget) begin
            value = 8'($urandom_range(0, 255));
            pick  = $urandom_range(0, 19);
            len   = (pick < 13) ? $urandom_range(1, 3)
                  : (pick < 19) ? $urandom_range(4, 12) : $urandom_range(20, 40);
            for (int i = 0; i < len; i++) begin
                offer_word(value, (i == len - 1) && ($urandom_range(0, 5) == 0));
            end
        end
    endtask

    task automatic expand_phase(input int budget);
        int         start;
        int         pick;
        logic [7:0] head;
        start = words_sent;
        while (words_sent - start < budget) begin
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                offer_word(8'($urandom_range(0, 127)), $urandom_range(0, 7) == 0);
            end else if (pick < 17) begin
                head = HDR_FLAG | 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                                  : $urandom_range(0, 7));
                offer_word(head, 1'b0);
                offer_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else if (pick < 19) begin
                offer_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                offer_word(HDR_FLAG | 8'($urandom_range(0, 127)), 1'b1);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        offer_word(8'h00, 1'b0);
        offer_word(8'h00, 1'b0);
        offer_word(8'h7F, 1'b0);
        offer_word(HDR_FLAG, 1'b0);
        offer_word(8'hFF, 1'b0);
        offer_word(8'hFF, 1'b0);
        offer_word(8'h01, 1'b1);
        offer_word(8'hAA, 1'b1);
        offer_word(8'h12, 1'b0);
        offer_word(8'h12, 1'b1);
        offer_word(8'h33, 1'b0);
        set_direction(DIR_COMPRESS);
        offer_word(8'h33, 1'b1);

        set_direction(DIR_EXPAND);
        offer_word(8'h00, 1'b0);
        offer_word(8'h7F, 1'b0);
        offer_word(HDR_FLAG, 1'b0);
        offer_word(8'hAB, 1'b0);
        offer_word(8'hFF, 1'b0);
        offer_word(8'h5A, 1'b0);
        offer_word(8'h87, 1'b0);
        offer_word(HDR_FLAG, 1'b0);
        offer_word(8'h88, 1'b0);
        offer_word(8'h01, 1'b0);
        offer_word(8'h85, 1'b1);
        offer_word(8'h10, 1'b1);
        offer_word(8'h90, 1'b0);
        set_direction(DIR_EXPAND);
        offer_word(8'h41, 1'b1);

        set_direction(DIR_COMPRESS);
        compress_phase(13, 1'b1);
        set_direction(DIR_EXPAND);
        expand_phase(13);
        set_direction(DIR_COMPRESS);
        compress_phase(13, 1'b0);
        set_direction(DIR_EXPAND);
        expand_phase(13);
        set_direction(DIR_COMPRESS);
        compress_phase(12, 1'b0);
        set_direction(DIR_EXPAND);
        expand_phase(11);

        drain_block();
        repeat (16) @(posedge aclk);
        $display("Sent %0d input words across %0d direction writes, both modes covered.",
                 words_sent, dir_writes);
        $display("Checked %0d result words, including full runs and 16-word expansions.",
                 beats_checked);
        if (mismatches == 0) begin
            $display("tb_byte_rle_codec_core: clean");
        end else begin
            $display("tb_byte_rle_codec_core: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d result words still outstanding.", beats_pending);
        $display("tb_byte_rle_codec_core: errors");
        $finish;
    end

endmodule
